[rtl/integer_calculator_alu_unit_defines.svh]
// Assertion macros used by the checker file of the integer ALU unit.
`ifndef INTEGER_CALCULATOR_ALU_UNIT_DEFINES_SVH
`define INTEGER_CALCULATOR_ALU_UNIT_DEFINES_SVH

// Generic clocked property with asynchronous active-low reset.
`define ICA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ica assertion failed");

// Signal holds its value in the cycle after cond.
`define ICA_ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
        else $error("ica hold assertion failed");

`endif

[rtl/ica_pkg.sv]
// Types and constants of the integer ALU unit.
`default_nettype none
package ica_pkg;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_POW  = 3'd4;
    localparam logic [2:0] OP_SQRT = 3'd5;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_DIV_ZERO = 3'd1;
    localparam logic [2:0] ERR_NEG_EXP  = 3'd2;
    localparam logic [2:0] ERR_NEG_ROOT = 3'd3;
    localparam logic [2:0] ERR_POW_OVF  = 3'd4;

    localparam logic [2:0] KIND_DONE = 3'd0;
    localparam logic [2:0] KIND_MUL  = 3'd1;
    localparam logic [2:0] KIND_DIV  = 3'd2;
    localparam logic [2:0] KIND_POW  = 3'd3;
    localparam logic [2:0] KIND_SQRT = 3'd4;

    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } ica_req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         error_code;
    } ica_rsp_t;

    // Classified work item; for KIND_DONE opa carries the final result.
    typedef struct packed {
        logic [2:0]  kind;
        logic        neg;
        logic [31:0] opa;
        logic [31:0] opb;
        logic [2:0]  err;
    } ica_entry_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

endpackage
`default_nettype wire

[rtl/ica_front.sv]
// Front end: decodes an operation and resolves the simple and special cases.
`default_nettype none
module ica_front (
    input  ica_pkg::ica_req_t   req,
    output ica_pkg::ica_entry_t entry
);
    import ica_pkg::*;

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] ma;
    logic [31:0] mb;

    assign a  = req.operand_a;
    assign b  = req.operand_b;
    assign ma = mag32(a);
    assign mb = mag32(b);

    always_comb
    begin
        entry.kind = KIND_DONE;
        entry.neg  = 1'b0;
        entry.opa  = a;
        entry.opb  = b;
        entry.err  = ERR_OK;
        unique case (req.operation)
            OP_ADD:
            begin
                entry.opa = a + b;
            end
            OP_SUB:
            begin
                entry.opa = a - b;
            end
            OP_MUL:
            begin
                entry.kind = KIND_MUL;
            end
            OP_DIV:
            begin
                if (b == 32'd0)
                begin
                    entry.err = ERR_DIV_ZERO;
                end
                else
                begin
                    entry.kind = KIND_DIV;
                    entry.opa  = ma;
                    entry.opb  = mb;
                    entry.neg  = a[31] ^ b[31];
                end
            end
            OP_POW:
            begin
                if (b[31])
                begin
                    entry.err = ERR_NEG_EXP;
                end
                else if (b == 32'd0)
                begin
                    entry.opa = 32'd1;
                end
                else if (ma == 32'd0)
                begin
                    entry.opa = 32'd0;
                end
                else if (ma == 32'd1)
                begin
                    entry.opa = (a[31] && b[0]) ? 32'hFFFF_FFFF : 32'd1;
                end
                else
                begin
                    entry.kind = KIND_POW;
                    entry.opa  = ma;
                    entry.neg  = a[31] && b[0];
                end
            end
            OP_SQRT:
            begin
                if (a[31])
                begin
                    entry.err = ERR_NEG_ROOT;
                end
                else
                begin
                    entry.kind = KIND_SQRT;
                end
            end
            default:
            begin
                entry.opa = a;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/ica_queue.sv]
// Small flop-based FIFO between the front end and the execution back end.
`default_nettype none
module ica_queue #(
    parameter int DEPTH = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  ica_pkg::ica_entry_t  wr_data,
    input  wire                  pop,
    output ica_pkg::ica_entry_t  head,
    output logic                 full,
    output logic                 empty
);
    import ica_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    ica_entry_t    mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

[rtl/ica_back.sv]
// Back end: shared multiplier and shift-subtract unit, plus the result register.
`default_nettype none
module ica_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ica_pkg::ica_entry_t  head,
    input  wire                  empty,
    output logic                 pop,
    output logic                 rsp_valid,
    input  wire                  rsp_stall,
    output ica_pkg::ica_rsp_t    rsp
);
    import ica_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]  state_reg,     state_next;
    logic [2:0]  kind_reg,      kind_next;
    logic        neg_reg,       neg_next;
    logic [31:0] acc_reg,       acc_next;
    logic [31:0] base_reg,      base_next;
    logic [31:0] rem_reg,       rem_next;
    logic [31:0] expo_reg,      expo_next;
    logic [5:0]  cnt_reg,       cnt_next;
    logic [31:0] res_reg,       res_next;
    logic [2:0]  err_reg,       err_next;
    logic        rsp_valid_reg, rsp_valid_next;
    ica_rsp_t    rsp_reg,       rsp_next;

    logic [63:0] prod;
    logic [32:0] div_sh;
    logic [32:0] div_diff;
    logic        div_ge;
    logic [31:0] quo;
    logic [31:0] sq_trial;
    logic        sq_ge;
    logic [31:0] root_new;
    logic        out_free;

    assign prod     = acc_reg * base_reg;
    assign div_sh   = {rem_reg, acc_reg[31]};
    assign div_ge   = div_sh >= {1'b0, base_reg};
    assign div_diff = div_sh - {1'b0, base_reg};
    assign quo      = {acc_reg[30:0], div_ge};
    assign sq_trial = acc_reg + base_reg;
    assign sq_ge    = rem_reg >= sq_trial;
    assign root_new = sq_ge ? ({1'b0, acc_reg[31:1]} + base_reg) : {1'b0, acc_reg[31:1]};
    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        rem_next       = rem_reg;
        expo_next      = expo_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        pop            = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    if (head.kind == KIND_DONE)
                    begin
                        if (out_free)
                        begin
                            pop                   = 1'b1;
                            rsp_next.result_value = head.opa;
                            rsp_next.error_code   = head.err;
                            rsp_valid_next        = 1'b1;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        kind_next  = head.kind;
                        neg_next   = head.neg;
                        cnt_next   = '0;
                        state_next = S_RUN;
                        case (head.kind)
                            KIND_MUL:
                            begin
                                acc_next  = head.opa;
                                base_next = head.opb;
                            end
                            KIND_DIV:
                            begin
                                acc_next  = head.opa;
                                base_next = head.opb;
                                rem_next  = '0;
                            end
                            KIND_POW:
                            begin
                                acc_next  = 32'd1;
                                base_next = head.opa;
                                expo_next = head.opb;
                            end
                            default:
                            begin
                                rem_next  = head.opa;
                                acc_next  = '0;
                                base_next = 32'h4000_0000;
                            end
                        endcase
                    end
                end
            end
            S_RUN:
            begin
                case (kind_reg)
                    KIND_MUL:
                    begin
                        res_next   = prod[31:0];
                        err_next   = ERR_OK;
                        state_next = S_FIN;
                    end
                    KIND_DIV:
                    begin
                        rem_next = div_ge ? div_diff[31:0] : div_sh[31:0];
                        acc_next = quo;
                        cnt_next = cnt_reg + 6'd1;
                        if (cnt_reg == 6'd31)
                        begin
                            res_next   = neg_reg ? (32'd0 - quo) : quo;
                            err_next   = ERR_OK;
                            state_next = S_FIN;
                        end
                    end
                    KIND_POW:
                    begin
                        acc_next = prod[31:0];
                        cnt_next = cnt_reg + 6'd1;
                        if (prod > 64'h8000_0000)
                        begin
                            res_next   = neg_reg ? INT_MIN : INT_MAX;
                            err_next   = ERR_POW_OVF;
                            state_next = S_FIN;
                        end
                        else if (({26'd0, cnt_reg} + 32'd1) == expo_reg)
                        begin
                            state_next = S_FIN;
                            if (neg_reg)
                            begin
                                res_next = 32'd0 - prod[31:0];
                                err_next = ERR_OK;
                            end
                            else if (prod[31])
                            begin
                                res_next = INT_MAX;
                                err_next = ERR_POW_OVF;
                            end
                            else
                            begin
                                res_next = prod[31:0];
                                err_next = ERR_OK;
                            end
                        end
                    end
                    default:
                    begin
                        rem_next  = sq_ge ? (rem_reg - sq_trial) : rem_reg;
                        acc_next  = root_new;
                        base_next = {2'b00, base_reg[31:2]};
                        cnt_next  = cnt_reg + 6'd1;
                        if (cnt_reg == 6'd15)
                        begin
                            res_next   = root_new;
                            err_next   = ERR_OK;
                            state_next = S_FIN;
                        end
                    end
                endcase
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_next.result_value = res_reg;
                    rsp_next.error_code   = err_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        rem_reg  <= rem_next;
        expo_reg <= expo_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
        rsp_reg  <= rsp_next;
    end

endmodule
`default_nettype wire

[rtl/integer_calculator_alu_unit.sv]
// Integer ALU unit: front decode, work queue, and execution back end.
// Signed 32-bit ALU with add, subtract, multiply, truncating divide, saturating
// power and floor square root; one result per request, in order. The front end
// takes one request per cycle while the queue (QUEUE_DEPTH entries) has room.
// Add, subtract, unknown opcodes, error cases and trivial powers leave the back
// end at one per cycle while the output is not stalled. Long operations run one
// at a time on the shared back-end datapath: multiply uses the multiplier once,
// divide yields one quotient bit per cycle, square root one root bit per cycle,
// power one multiply per cycle, ending at the exponent or on overflow.
`default_nettype none
module integer_calculator_alu_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    output logic              req_stall,
    input  ica_pkg::ica_req_t req,
    output logic              rsp_valid,
    input  wire               rsp_stall,
    output ica_pkg::ica_rsp_t rsp
);
    import ica_pkg::*;

    ica_entry_t entry;
    ica_entry_t head;
    logic       full;
    logic       empty;
    logic       pop;

    assign req_stall = full;

    ica_front u_front (
        .req   (req),
        .entry (entry)
    );

    ica_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (req_valid && !full),
        .wr_data (entry),
        .pop     (pop),
        .head    (head),
        .full    (full),
        .empty   (empty)
    );

    ica_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

[rtl/ica_checker.sv]
// Port-level checker for the integer ALU unit, bound to the top level.
`default_nettype none
`include "integer_calculator_alu_unit_defines.svh"
module ica_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               rsp_valid,
    input wire               rsp_stall,
    input ica_pkg::ica_rsp_t rsp
);
    import ica_pkg::*;

    `ICA_ASSERT(a_rsp_valid_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid)
    `ICA_ASSERT_HOLD(a_rsp_data_hold, clk, rst_n, rsp_valid && rsp_stall, rsp)
    `ICA_ASSERT(a_err_range, clk, rst_n, rsp_valid |-> (rsp.error_code <= ERR_POW_OVF))
    `ICA_ASSERT(a_ovf_saturates, clk, rst_n, rsp_valid && (rsp.error_code == ERR_POW_OVF) |-> (rsp.result_value == INT_MAX) || (rsp.result_value == INT_MIN))

endmodule

bind integer_calculator_alu_unit ica_checker u_ica_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
`default_nettype wire

[sim/integer_calculator_alu_unit_test.sv]
// Testbench for the integer ALU unit: random and directed operations checked against a predictor.
`default_nettype none
module integer_calculator_alu_unit_test;
    import ica_pkg::*;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    ica_req_t req;
    logic rsp_valid;
    logic rsp_stall;
    ica_rsp_t rsp;

    integer_calculator_alu_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    ica_req_t pending_ops[$];
    ica_rsp_t expected_results[$];
    int errors = 0;
    int cycles = 0;
    bit stimulus_done = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int hold_cycles = 0;
    int hold_trigger = 0;

    localparam int CYCLE_LIMIT = 400000;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] floor_root(input logic [31:0] v);
        logic [31:0] rem;
        logic [31:0] root;
        logic [31:0] bitv;
        rem = v;
        root = 0;
        bitv = 32'h4000_0000;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic ica_rsp_t alu_result(input ica_req_t r);
        ica_rsp_t o;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] q;
        logic [63:0] base;
        logic [63:0] mag;
        logic neg;
        logic ovf;
        a = r.operand_a;
        b = r.operand_b;
        o.result_value = a;
        o.error_code = ERR_OK;
        case (r.operation)
            OP_ADD: o.result_value = a + b;
            OP_SUB: o.result_value = a - b;
            OP_MUL: o.result_value = a * b;
            OP_DIV:
                if (b == 0)
                    o.error_code = ERR_DIV_ZERO;
                else
                begin
                    q = abs32(a) / abs32(b);
                    o.result_value = (a[31] ^ b[31]) ? (32'd0 - q) : q;
                end
            OP_POW:
                if (b[31])
                    o.error_code = ERR_NEG_EXP;
                else
                begin
                    base = {32'd0, abs32(a)};
                    neg = a[31] & b[0];
                    mag = 1;
                    ovf = 0;
                    if (b == 0)
                        o.result_value = 1;
                    else if (base == 0)
                        o.result_value = 0;
                    else if (base == 1)
                        o.result_value = neg ? 32'hFFFF_FFFF : 32'd1;
                    else
                    begin
                        for (logic [31:0] i = 0; i < b && !ovf; i++)
                        begin
                            mag = mag * base;
                            if (mag > 64'h8000_0000) ovf = 1;
                        end
                        if (neg)
                        begin
                            o.result_value = ovf ? INT_MIN : (32'd0 - mag[31:0]);
                            if (ovf) o.error_code = ERR_POW_OVF;
                        end
                        else if (ovf || mag > 64'h7FFF_FFFF)
                        begin
                            o.result_value = INT_MAX;
                            o.error_code = ERR_POW_OVF;
                        end
                        else
                            o.result_value = mag[31:0];
                    end
                end
            OP_SQRT:
                if (a[31])
                    o.error_code = ERR_NEG_ROOT;
                else
                    o.result_value = floor_root(a);
            default: ;
        endcase
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return 32'd0 - $urandom_range(0, 20);
            2: return INT_MAX - $urandom_range(0, 3);
            3: return INT_MIN + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b);
        ica_req_t r;
        r.operation = op;
        r.operand_a = a;
        r.operand_b = b;
        pending_ops.push_back(r);
    endtask

    initial
    begin
        ica_req_t r;
        queue_op(OP_ADD, INT_MAX, 1);
        queue_op(OP_SUB, INT_MIN, 1);
        queue_op(OP_MUL, INT_MAX, INT_MAX);
        queue_op(OP_MUL, 32'hFFFF_FFFF, INT_MIN);
        queue_op(OP_DIV, 7, 0);
        queue_op(OP_DIV, INT_MIN, 32'hFFFF_FFFF);
        queue_op(OP_DIV, -7, 2);
        queue_op(OP_DIV, 7, -2);
        queue_op(OP_POW, 0, 0);
        queue_op(OP_POW, 5, -1);
        queue_op(OP_POW, 2, 31);
        queue_op(OP_POW, -2, 31);
        queue_op(OP_POW, -2, 32);
        queue_op(OP_POW, 3, 40);
        queue_op(OP_POW, -1, INT_MAX);
        queue_op(OP_POW, 1, INT_MAX);
        queue_op(OP_POW, 0, 9);
        queue_op(OP_POW, 46341, 2);
        queue_op(OP_SQRT, INT_MAX, 0);
        queue_op(OP_SQRT, -1, 0);
        queue_op(OP_SQRT, 0, 0);
        queue_op(3'd6, INT_MIN, INT_MAX);
        queue_op(3'd7, 32'h5555_5555, 32'hAAAA_AAAA);
        repeat (600)
        begin
            r.operation = 3'($urandom_range(0, 7));
            r.operand_a = rand_operand();
            r.operand_b = rand_operand();
            if (r.operation == OP_POW && $urandom_range(0, 3) != 0)
                r.operand_b = $urandom_range(0, 40);
            pending_ops.push_back(r);
        end
        hold_trigger = $urandom_range(50, 300);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 0;
            req <= '0;
            send_wait <= 0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid && !req_stall)
                expected_results.push_back(alu_result(req));
            if (send_wait > 0)
            begin
                send_wait <= send_wait - 1;
                req_valid <= 0;
            end
            else if (pending_ops.size() > 0)
            begin
                req <= pending_ops.pop_front();
                req_valid <= 1;
                send_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : 0;
            end
            else
            begin
                req_valid <= 0;
                stimulus_done <= 1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        ica_rsp_t e;
        if (!rst_n)
        begin
            rsp_stall <= 0;
            recv_wait <= 0;
            hold_cycles <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("transfer with no expected result");
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (rsp.result_value !== e.result_value)
                    begin
                        $error("result_value expected %h actual %h",
                               e.result_value, rsp.result_value);
                        errors++;
                    end
                    if (rsp.error_code !== e.error_code)
                    begin
                        $error("error_code expected %0d actual %0d",
                               e.error_code, rsp.error_code);
                        errors++;
                    end
                end
            end
            if (cycles == hold_trigger)
            begin
                hold_cycles <= 300;
                rsp_stall <= 1;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                rsp_stall <= 1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                rsp_stall <= 1;
            end
            else if (rsp_valid && !rsp_stall && $urandom_range(0, 2) == 0)
            begin
                recv_wait <= $urandom_range(0, 10);
                rsp_stall <= 1;
            end
            else
                rsp_stall <= 0;
        end
    end

    initial
    begin
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        while (!(stimulus_done && expected_results.size() == 0) && cycles < CYCLE_LIMIT)
            @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            repeat (50) @(posedge clk);
            if (errors == 0 && expected_results.size() == 0)
                $display("status: pass");
            else
                $display("status: fail");
            $finish;
        end
    end
endmodule
`default_nettype wire
